[rtl/core/bcgl_pkg.sv]
// Shared constants, item types and action codes of the calibration grid lookup.
package bcgl_pkg;

   localparam int MAX_ROWS         = 32;
   localparam int MAX_POWER_POINTS = 32;
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_POWER_POINTS);
   localparam int AX_W    = (ROW_W > COL_W) ? ROW_W : COL_W;
   localparam int CELL_AW = ROW_W + COL_W;
   localparam int CNT_W   = 6;
   localparam int CSR_W   = 6;

   localparam int KEY_W  = 26;
   localparam int DIV_W  = 25;
   localparam int FRAC_W = 16;
   localparam int Q_W    = FRAC_W + 1;
   localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;

   localparam logic [2:0] ACT_QUERY    = 3'd0;
   localparam logic [2:0] ACT_WR_POWER = 3'd1;
   localparam logic [2:0] ACT_WR_FREQ  = 3'd2;
   localparam logic [2:0] ACT_WR_CELL  = 3'd3;
   localparam logic [2:0] ACT_CLR_CELL = 3'd4;

   localparam logic CSR_ROWS   = 1'b0;
   localparam logic CSR_POINTS = 1'b1;

   typedef struct packed {
      logic [2:0]         action;
      logic [4:0]         row_index;
      logic [4:0]         power_index;
      logic [23:0]        frequency_khz;
      logic signed [15:0] power_cdb;
      logic signed [15:0] correction_cdb;
   } req_type;

   typedef struct packed {
      logic signed [15:0] correction_out;
      logic               status;
   } rsp_type;

endpackage

[rtl/core/bcgl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bcgl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bcgl_div.sv]
// Restoring divider that forms a rounded Q1.16 weight, one quotient bit per cycle.
module bcgl_div import bcgl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic [Q_W-1:0]   quot
);

   localparam int D_W   = DIV_W + FRAC_W;
   localparam int CNT_D = $clog2(Q_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [Q_W-1:0]   sh_ff, sh_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_D-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [D_W-1:0]   dividend;
   logic [DIV_W:0]   trial;

   always_comb begin
      dividend = {num, {FRAC_W{1'b0}}} + D_W'(den >> 1);
      trial    = {rem_ff, sh_ff[Q_W-1]};
      rem_in   = rem_ff;
      den_in   = den_ff;
      sh_in    = sh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in = DIV_W'(dividend[D_W-1:Q_W]);
         sh_in  = dividend[Q_W-1:0];
         den_in = den;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         sh_in = sh_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            q_in   = {q_ff[Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_D'(Q_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

[rtl/core/bilinear_calibration_grid_lookup.sv]
// Top level of the calibration grid lookup: sequencer, axis and cell memories, mixer.
// Writes, clears and unknown actions pass from acceptance through S_EXEC and S_FIN to the
// result item. A query on a non-empty grid runs two bracket scans, up to two weight
// divisions and four nearest-cell walks; the registered read data of the axis and cell
// memories sets the pace. One item is worked on at a time. After reset a clearing pass
// empties every word of the cell memory; no item is accepted before it ends, while
// register writes are taken.
module bilinear_calibration_grid_lookup import bcgl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   // Sequencer states: each memory read is issued in one state and checked in the next.
   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_EXEC,
      S_B0, S_C0, S_BL, S_CL, S_BI, S_CI,
      S_WT, S_WW,
      S_CSTEP, S_CCHK,
      S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_RND,
      S_FIN
   } state_type;

   localparam int MUL_X_W = 34;
   localparam int MUL_Y_W = Q_W + 1;
   localparam int ACC_W   = MUL_X_W + MUL_Y_W;

   state_type                   state_ff, state_in;
   req_type                     item_ff, item_in;
   logic [CSR_W-1:0]            rows_ff, rows_in;
   logic [CSR_W-1:0]            pts_ff, pts_in;
   logic [CELL_AW-1:0]          clr_ff, clr_in;
   logic                        phase_ff, phase_in;
   logic [CNT_W-1:0]            scan_ff, scan_in;
   logic signed [KEY_W-1:0]     prev_ff, prev_in;
   logic [AX_W-1:0]             lo_ff, lo_in;
   logic [AX_W-1:0]             hi_ff, hi_in;
   logic signed [KEY_W-1:0]     p0_ff, p0_in;
   logic signed [KEY_W-1:0]     p1_ff, p1_in;
   logic [COL_W-1:0]            plo_ff, plo_in;
   logic [COL_W-1:0]            phi_ff, phi_in;
   logic [ROW_W-1:0]            flo_ff, flo_in;
   logic [ROW_W-1:0]            fhi_ff, fhi_in;
   logic [Q_W-1:0]              tp_ff, tp_in;
   logic [Q_W-1:0]              tf_ff, tf_in;
   logic [1:0]                  corner_ff, corner_in;
   logic [CNT_W-1:0]            off_ff, off_in;
   logic                        side_ff, side_in;
   logic signed [15:0]          v_ff [4];
   logic signed [15:0]          v_in [4];
   logic signed [MUL_X_W-1:0]   a_ff, a_in;
   logic signed [MUL_X_W-1:0]   b_ff, b_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [15:0]          res_ff, res_in;
   logic                        stat_ff, stat_in;
   rsp_type                     rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Counts in use, clamped to the grid size.
   logic [CNT_W-1:0] nr, np, n_ax;
   logic             row_ok, col_ok;

   // Memory ports.
   logic               pow_we, frq_we, cel_we;
   logic [COL_W-1:0]   pow_raddr;
   logic [ROW_W-1:0]   frq_raddr;
   logic [CELL_AW-1:0] cel_waddr, cel_raddr;
   logic [16:0]        cel_wdata, cel_rd;
   logic [15:0]        pow_rd;
   logic [23:0]        frq_rd;
   logic [AX_W-1:0]    ax_raddr;

   // Bracket and weight datapath.
   logic signed [KEY_W-1:0] key, ax_val;
   logic signed [KEY_W-1:0] w_num, w_den;
   logic                    div_start, div_done;
   logic [Q_W-1:0]          div_q;
   logic                    w_ready;
   logic [Q_W-1:0]          w_val;
   logic [CNT_W-1:0]        n_last;

   // Nearest-cell walk.
   logic [ROW_W-1:0]  c_row;
   logic [COL_W-1:0]  c_col;
   logic [CNT_W:0]    c_hi;
   logic              c_valid, c_last;
   logic [COL_W-1:0]  c_cand;

   // Mixer.
   logic signed [MUL_X_W-1:0] mul_x;
   logic signed [MUL_Y_W-1:0] mul_y;
   logic signed [ACC_W-1:0]   prod;
   logic signed [19:0]        rnd;

   assign nr = (rows_ff > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_ff;
   assign np = (pts_ff > CNT_W'(MAX_POWER_POINTS)) ? CNT_W'(MAX_POWER_POINTS) : pts_ff;
   assign n_ax   = phase_ff ? nr : np;
   assign n_last = n_ax - 1'b1;
   assign row_ok = CNT_W'(item_ff.row_index) < nr;
   assign col_ok = CNT_W'(item_ff.power_index) < np;

   // The power axis is scanned first with a signed key, then the frequency axis.
   assign key    = phase_ff ? KEY_W'(signed'({1'b0, item_ff.frequency_khz}))
                            : KEY_W'(item_ff.power_cdb);
   assign ax_val = phase_ff ? KEY_W'(signed'({1'b0, frq_rd}))
                            : KEY_W'(signed'(pow_rd));

   always_comb begin
      case (state_ff)
         S_B0:    ax_raddr = '0;
         S_BL:    ax_raddr = n_last[AX_W-1:0];
         default: ax_raddr = scan_ff[AX_W-1:0];
      endcase
   end
   assign pow_raddr = ax_raddr[COL_W-1:0];
   assign frq_raddr = ax_raddr[ROW_W-1:0];

   assign pow_we = (state_ff == S_EXEC) && (item_ff.action == ACT_WR_POWER) && col_ok;
   assign frq_we = (state_ff == S_EXEC) && (item_ff.action == ACT_WR_FREQ) && row_ok;

   always_comb begin
      cel_we    = 1'b0;
      cel_waddr = {item_ff.row_index[ROW_W-1:0], item_ff.power_index[COL_W-1:0]};
      cel_wdata = {1'b1, item_ff.correction_cdb};
      if (state_ff == S_CLEAR) begin
         cel_we    = 1'b1;
         cel_waddr = clr_ff;
         cel_wdata = '0;
      end else if (state_ff == S_EXEC && row_ok && col_ok) begin
         if (item_ff.action == ACT_WR_CELL) begin
            cel_we = 1'b1;
         end else if (item_ff.action == ACT_CLR_CELL) begin
            cel_we    = 1'b1;
            cel_wdata = '0;
         end
      end
   end

   bcgl_ram #(.WIDTH(16), .DEPTH(MAX_POWER_POINTS)) u_power_axis (
      .clock   (clock),
      .wr_en   (pow_we),
      .wr_addr (item_ff.power_index[COL_W-1:0]),
      .wr_data (item_ff.power_cdb),
      .rd_addr (pow_raddr),
      .rd_data (pow_rd)
   );

   bcgl_ram #(.WIDTH(24), .DEPTH(MAX_ROWS)) u_row_freq (
      .clock   (clock),
      .wr_en   (frq_we),
      .wr_addr (item_ff.row_index[ROW_W-1:0]),
      .wr_data (item_ff.frequency_khz),
      .rd_addr (frq_raddr),
      .rd_data (frq_rd)
   );

   // Each cell word holds its set mark above the 16-bit value.
   bcgl_ram #(.WIDTH(17), .DEPTH(MAX_ROWS * MAX_POWER_POINTS)) u_cells (
      .clock   (clock),
      .wr_en   (cel_we),
      .wr_addr (cel_waddr),
      .wr_data (cel_wdata),
      .rd_addr (cel_raddr),
      .rd_data (cel_rd)
   );

   // Weight of a bracket: zero for a single point, a reversed pair or a key at or below
   // the lower point, one at or above the upper point, and a rounded quotient otherwise.
   assign w_num = key - p0_ff;
   assign w_den = p1_ff - p0_ff;

   always_comb begin
      div_start = 1'b0;
      w_ready   = 1'b0;
      w_val     = '0;
      if (state_ff == S_WT) begin
         if (lo_ff == hi_ff || w_den <= 0 || w_num <= 0) begin
            w_ready = 1'b1;
         end else if (w_num >= w_den) begin
            w_ready = 1'b1;
            w_val   = Q_ONE;
         end else begin
            div_start = 1'b1;
         end
      end else if (state_ff == S_WW && div_done) begin
         w_ready = 1'b1;
         w_val   = div_q;
      end
   end

   bcgl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (w_num[DIV_W-1:0]),
      .den   (w_den[DIV_W-1:0]),
      .done  (div_done),
      .quot  (div_q)
   );

   // Nearest set cell: the lower neighbor at each distance is tried before the upper one.
   assign c_row  = corner_ff[1] ? fhi_ff : flo_ff;
   assign c_col  = corner_ff[0] ? phi_ff : plo_ff;
   assign c_hi   = (CNT_W + 1)'(c_col) + (CNT_W + 1)'(off_ff);
   assign c_last = side_ff && ((off_ff + 1'b1) == np);

   always_comb begin
      if (!side_ff) begin
         c_valid = off_ff <= CNT_W'(c_col);
         c_cand  = COL_W'(CNT_W'(c_col) - off_ff);
      end else begin
         c_valid = (off_ff != '0) && (c_hi < (CNT_W + 1)'(np));
         c_cand  = c_hi[COL_W-1:0];
      end
   end
   assign cel_raddr = {c_row, c_cand};

   // One shared multiplier forms the two row blends and then the column blend.
   always_comb begin
      mul_x = MUL_X_W'(v_ff[0]);
      mul_y = MUL_Y_W'(Q_ONE - tp_ff);
      case (state_ff)
         S_M2: begin
            mul_x = MUL_X_W'(v_ff[1]);
            mul_y = MUL_Y_W'(tp_ff);
         end
         S_M3: begin
            mul_x = MUL_X_W'(v_ff[2]);
         end
         S_M4: begin
            mul_x = MUL_X_W'(v_ff[3]);
            mul_y = MUL_Y_W'(tp_ff);
         end
         S_M5: begin
            mul_x = a_ff;
            mul_y = MUL_Y_W'(Q_ONE - tf_ff);
         end
         S_M6: begin
            mul_x = b_ff;
            mul_y = MUL_Y_W'(tf_ff);
         end
         default: begin
         end
      endcase
      prod = ACC_W'(mul_x) * ACC_W'(mul_y);
   end

   // The sum already carries the rounding half, so a floor shift finishes the rounding.
   assign rnd = acc_ff[ACC_W-1:32];

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rows_in      = rows_ff;
      pts_in       = pts_ff;
      clr_in       = clr_ff;
      phase_in     = phase_ff;
      scan_in      = scan_ff;
      prev_in      = prev_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      flo_in       = flo_ff;
      fhi_in       = fhi_ff;
      tp_in        = tp_ff;
      tf_in        = tf_ff;
      corner_in    = corner_ff;
      off_in       = off_ff;
      side_in      = side_ff;
      v_in         = v_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROWS:   rows_in = csr_data;
            CSR_POINTS: pts_in  = csr_data;
            default:    rows_in = rows_ff;
         endcase
      end

      unique case (state_ff) inside
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in   = '0;
            stat_in  = 1'b0;
            state_in = S_FIN;
            case (item_ff.action) inside
               ACT_QUERY: begin
                  if (nr != '0 && np != '0) begin
                     phase_in = 1'b0;
                     state_in = S_B0;
                  end
               end
               ACT_WR_POWER: stat_in = !col_ok;
               ACT_WR_FREQ:  stat_in = !row_ok;
               ACT_WR_CELL, ACT_CLR_CELL: stat_in = !(row_ok && col_ok);
               default: stat_in = 1'b0;
            endcase
         end
         S_B0: state_in = S_C0;
         S_C0: begin
            prev_in = ax_val;
            if (key <= ax_val) begin
               lo_in    = '0;
               hi_in    = '0;
               state_in = S_WT;
            end else begin
               state_in = S_BL;
            end
         end
         S_BL: state_in = S_CL;
         S_CL: begin
            if (key >= ax_val) begin
               lo_in    = n_last[AX_W-1:0];
               hi_in    = n_last[AX_W-1:0];
               state_in = S_WT;
            end else begin
               scan_in  = CNT_W'(1);
               state_in = S_BI;
            end
         end
         S_BI: state_in = S_CI;
         S_CI: begin
            if (ax_val >= key) begin
               lo_in    = AX_W'(scan_ff - 1'b1);
               hi_in    = scan_ff[AX_W-1:0];
               p0_in    = prev_ff;
               p1_in    = ax_val;
               state_in = S_WT;
            end else if ((scan_ff + 1'b1) == n_ax) begin
               lo_in    = n_last[AX_W-1:0];
               hi_in    = n_last[AX_W-1:0];
               state_in = S_WT;
            end else begin
               prev_in  = ax_val;
               scan_in  = scan_ff + 1'b1;
               state_in = S_BI;
            end
         end
         S_WT, S_WW: begin
            if (state_ff == S_WT && !w_ready) begin
               state_in = S_WW;
            end
            if (w_ready) begin
               if (!phase_ff) begin
                  tp_in    = w_val;
                  plo_in   = lo_ff[COL_W-1:0];
                  phi_in   = hi_ff[COL_W-1:0];
                  phase_in = 1'b1;
                  state_in = S_B0;
               end else begin
                  tf_in     = w_val;
                  flo_in    = lo_ff[ROW_W-1:0];
                  fhi_in    = hi_ff[ROW_W-1:0];
                  corner_in = '0;
                  off_in    = '0;
                  side_in   = 1'b0;
                  state_in  = S_CSTEP;
               end
            end
         end
         S_CSTEP, S_CCHK: begin
            if (state_ff == S_CSTEP && c_valid) begin
               state_in = S_CCHK;
            end else if (state_ff == S_CCHK && cel_rd[16]) begin
               v_in[corner_ff] = cel_rd[15:0];
               corner_in       = corner_ff + 1'b1;
               off_in          = '0;
               side_in         = 1'b0;
               state_in        = (corner_ff == 2'd3) ? S_M1 : S_CSTEP;
            end else if (c_last) begin
               v_in[corner_ff] = '0;
               corner_in       = corner_ff + 1'b1;
               off_in          = '0;
               side_in         = 1'b0;
               state_in        = (corner_ff == 2'd3) ? S_M1 : S_CSTEP;
            end else begin
               side_in  = !side_ff;
               off_in   = side_ff ? off_ff + 1'b1 : off_ff;
               state_in = S_CSTEP;
            end
         end
         S_M1: begin
            acc_in   = prod;
            state_in = S_M2;
         end
         S_M2: begin
            a_in     = MUL_X_W'(acc_ff + prod);
            state_in = S_M3;
         end
         S_M3: begin
            acc_in   = prod;
            state_in = S_M4;
         end
         S_M4: begin
            b_in     = MUL_X_W'(acc_ff + prod);
            state_in = S_M5;
         end
         S_M5: begin
            acc_in   = prod;
            state_in = S_M6;
         end
         S_M6: begin
            acc_in   = acc_ff + prod + (ACC_W'(1) <<< 31);
            state_in = S_RND;
         end
         S_RND: begin
            if (rnd > 20'sd32767) begin
               res_in = 16'sh7fff;
            end else if (rnd < -20'sd32768) begin
               res_in = 16'sh8000;
            end else begin
               res_in = rnd[15:0];
            end
            stat_in  = 1'b0;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.correction_out = res_ff;
               rsp_in.status         = stat_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rows_ff      <= '0;
         pts_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rows_ff      <= rows_in;
         pts_ff       <= pts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff   <= item_in;
      phase_ff  <= phase_in;
      scan_ff   <= scan_in;
      prev_ff   <= prev_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      flo_ff    <= flo_in;
      fhi_ff    <= fhi_in;
      tp_ff     <= tp_in;
      tf_ff     <= tf_in;
      corner_ff <= corner_in;
      off_ff    <= off_in;
      side_ff   <= side_in;
      v_ff      <= v_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      res_ff    <= res_in;
      stat_ff   <= stat_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

[verif/bilinear_calibration_grid_lookup_tb.sv]
// Self-checking testbench of the calibration grid lookup: directed and random axis, cell and query items.
`timescale 1ns / 100ps

module bilinear_calibration_grid_lookup_tb;
   import bcgl_pkg::*;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic             csr_index;
   logic [CSR_W-1:0] csr_data;

   bilinear_calibration_grid_lookup dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // The predictor keeps its own copy of the grid and the counts in use.
   logic [CNT_W-1:0]   rows_cfg, points_cfg;
   logic signed [15:0] axis_pwr [MAX_POWER_POINTS];
   logic [23:0]        axis_freq [MAX_ROWS];
   logic signed [15:0] grid_val [MAX_ROWS][MAX_POWER_POINTS];
   bit                 grid_set [MAX_ROWS][MAX_POWER_POINTS];

   req_type pending_items [$];
   rsp_type expected_rsps [$];
   int      error_count;
   int      rsp_count;
   int      query_count;
   longint  cycle_count;
   bit      hold_sender;
   bit      stall_free;
   bit      req_taken;
   int      send_gap;
   int      stall_len;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Any run slower than this limit is treated as a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("bilinear_calibration_grid_lookup_tb: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch #%0d at cycle %0d: %s got %0d expected %0d",
               rsp_count, cycle_count, what, got, want);
      error_count++;
   endtask

   task automatic enqueue_item(input req_type it);
      pending_items.insert(pending_items.size(), it);
   endtask

   // Bracket a key on an axis; the edges are checked first, as the block does.
   function automatic void find_bracket(input longint ax[MAX_ROWS], input int n,
                                        input longint key, output int lo, output int hi);
      lo = n - 1;
      hi = n - 1;
      if (key <= ax[0]) begin
         lo = 0;
         hi = 0;
         return;
      end
      if (key >= ax[n-1]) return;
      for (int i = 1; i < n; i++) begin
         if (ax[i] >= key) begin
            lo = i - 1;
            hi = i;
            return;
         end
      end
   endfunction

   function automatic longint q16_weight(input longint ax[MAX_ROWS], input int lo, input int hi,
                                         input longint key);
      longint num, den;
      if (lo == hi || ax[hi] <= ax[lo]) return 0;
      num = key - ax[lo];
      den = ax[hi] - ax[lo];
      if (num <= 0) return 0;
      if (num >= den) return 65536;
      return (num * 65536 + den / 2) / den;
   endfunction

   // An unset corner takes the nearest set cell of its row, lower side first.
   function automatic longint corner_value(input int row, input int col, input int np);
      int a, b;
      for (int off = 0; off < np; off++) begin
         a = col - off;
         b = col + off;
         if (a >= 0 && a < np && grid_set[row][a]) return grid_val[row][a];
         if (off != 0 && b < np && grid_set[row][b]) return grid_val[row][b];
      end
      return 0;
   endfunction

   function automatic rsp_type lookup_correction(input req_type it);
      rsp_type r;
      int nr, np, flo, fhi, plo, phi;
      longint fax[MAX_ROWS], pax[MAX_ROWS];
      longint tp, tf, a, b, s, q;
      r = '0;
      nr = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
      np = (points_cfg > MAX_POWER_POINTS) ? MAX_POWER_POINTS : points_cfg;
      case (it.action) inside
         ACT_QUERY: begin
            if (nr > 0 && np > 0) begin
               for (int i = 0; i < MAX_ROWS; i++) begin
                  fax[i] = axis_freq[i];
                  pax[i] = axis_pwr[i];
               end
               find_bracket(fax, nr, it.frequency_khz, flo, fhi);
               find_bracket(pax, np, it.power_cdb, plo, phi);
               tp = q16_weight(pax, plo, phi, it.power_cdb);
               tf = q16_weight(fax, flo, fhi, it.frequency_khz);
               a = corner_value(flo, plo, np) * (65536 - tp) + corner_value(flo, phi, np) * tp;
               b = corner_value(fhi, plo, np) * (65536 - tp) + corner_value(fhi, phi, np) * tp;
               s = a * (65536 - tf) + b * tf + (64'sd1 <<< 31);
               q = s >>> 32;
               if (q > 32767) q = 32767;
               if (q < -32768) q = -32768;
               r.correction_out = q[15:0];
            end
         end
         ACT_WR_POWER: begin
            if (it.power_index < np) axis_pwr[it.power_index] = it.power_cdb;
            else r.status = 1'b1;
         end
         ACT_WR_FREQ: begin
            if (it.row_index < nr) axis_freq[it.row_index] = it.frequency_khz;
            else r.status = 1'b1;
         end
         ACT_WR_CELL, ACT_CLR_CELL: begin
            if (it.row_index < nr && it.power_index < np) begin
               grid_set[it.row_index][it.power_index] = (it.action == ACT_WR_CELL);
               grid_val[it.row_index][it.power_index] =
                  (it.action == ACT_WR_CELL) ? it.correction_cdb : 16'sd0;
            end else begin
               r.status = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Driver: an item stays on the bus until it is taken, then a random gap may follow.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0 && !hold_sender) begin
         req_valid <= 1'b1;
         req_data <= pending_items.pop_front();
         req_taken = 1'b0;
         send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                 : $urandom_range(0, 2);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // The expectation is formed when the item is accepted.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         req_taken = 1'b1;
         expected_rsps.insert(expected_rsps.size(), lookup_correction(req_data));
         if (req_data.action == ACT_QUERY) query_count++;
      end
   end

   // Result stall: random stretches, with long free-running phases.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_len <= 0;
      end else if (stall_free) begin
         rsp_stall <= 1'b0;
      end else if (stall_len > 0) begin
         stall_len <= stall_len - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_len <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 70)
                                                  : $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result, correction", rsp_data.correction_out, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.correction_out !== want.correction_out)
               report_mismatch("correction_out", rsp_data.correction_out,
                               want.correction_out);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
         end
      end
   end

   task automatic write_csr(input logic idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_ROWS) rows_cfg = val;
      else points_cfg = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type make_item(input logic [2:0] act, input int ri, input int pi,
                                         input logic [23:0] f, input logic [15:0] p,
                                         input logic [15:0] c);
      req_type it;
      it.action = act;
      it.row_index = 5'(ri);
      it.power_index = 5'(pi);
      it.frequency_khz = f;
      it.power_cdb = p;
      it.correction_cdb = c;
      return it;
   endfunction

   // Fill both axes in ascending order so that no query reads an unwritten entry.
   task automatic load_axes(input int nr, input int np, input bit extremes);
      logic [23:0] f;
      logic signed [15:0] p;
      f = extremes ? 24'd0 : $urandom_range(0, 100000);
      p = extremes ? -16'sd32768 : -16'($urandom_range(0, 20000));
      for (int i = 0; i < nr; i++) begin
         enqueue_item(make_item(ACT_WR_FREQ, i, $urandom, f, $urandom, $urandom));
         f = (extremes && i == nr - 2) ? 24'hFFFFFF : f + $urandom_range(0, 300000);
      end
      for (int i = 0; i < np; i++) begin
         enqueue_item(make_item(ACT_WR_POWER, $urandom, i, $urandom, p, $urandom));
         p = (extremes && i == np - 2) ? 16'sd32767 : p + 16'($urandom_range(0, 1500));
      end
   endtask

   function automatic logic [23:0] axis_freq_hint(input int nr);
      longint v;
      v = longint'(axis_freq[$urandom_range(0, nr - 1)]) + $urandom_range(0, 600000) - 300000;
      if (v < 0) v = 0;
      if (v > 24'hFFFFFF) v = 24'hFFFFFF;
      return v[23:0];
   endfunction

   function automatic logic [15:0] axis_pwr_hint(input int np);
      longint v;
      v = longint'(axis_pwr[$urandom_range(0, np - 1)]) + $urandom_range(0, 3000) - 1500;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v[15:0];
   endfunction

   // A random item; most query keys stay within reach of the loaded axes.
   function automatic req_type random_item(input int nr, input int np);
      req_type it;
      int pick;
      it = req_type'({$urandom, $urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 45) it.action = ACT_QUERY;
      else if (pick < 75) it.action = ACT_WR_CELL;
      else if (pick < 87) it.action = ACT_CLR_CELL;
      else if (pick < 91) it.action = ACT_WR_FREQ;
      else if (pick < 95) it.action = ACT_WR_POWER;
      else it.action = $urandom_range(5, 7);
      if ((it.action == ACT_WR_FREQ || it.action == ACT_WR_POWER) && $urandom_range(0, 3) != 0)
         it.action = ACT_QUERY;
      if ($urandom_range(0, 7) != 0) begin
         it.row_index = $urandom_range(0, (nr > 0) ? nr - 1 : 0);
         it.power_index = $urandom_range(0, (np > 0) ? np - 1 : 0);
      end
      if (it.action == ACT_QUERY && $urandom_range(0, 3) != 0) begin
         it.frequency_khz = (nr > 0) ? axis_freq_hint(nr) : it.frequency_khz;
         it.power_cdb = (np > 0) ? axis_pwr_hint(np) : it.power_cdb;
      end
      return it;
   endfunction

   // Settings of the counts in use for successive phases, extremes included.
   int phase_rows [6] = '{1, 32, 2, 5, 63, 17};
   int phase_pts  [6] = '{1, 32, 63, 3, 8, 32};

   initial begin
      int nr, np;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_ROWS;
      csr_data = '0;
      rows_cfg = '0;
      points_cfg = '0;
      error_count = 0;
      rsp_count = 0;
      query_count = 0;
      cycle_count = 0;
      hold_sender = 1'b0;
      stall_free = 1'b0;
      req_taken = 1'b0;
      for (int r = 0; r < MAX_ROWS; r++)
         for (int c = 0; c < MAX_POWER_POINTS; c++) grid_set[r][c] = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with both counts zero: empty grid, out-of-use writes, unknown actions.
      enqueue_item(make_item(ACT_QUERY, 0, 0, 24'hFFFFFF, 16'h8000, 16'h7FFF));
      enqueue_item(make_item(ACT_WR_CELL, 0, 0, 0, 0, 16'h7FFF));
      enqueue_item(make_item(ACT_WR_POWER, 0, 31, 0, 16'h7FFF, 0));
      enqueue_item(make_item(ACT_WR_FREQ, 31, 0, 24'hFFFFFF, 0, 0));
      enqueue_item(make_item(ACT_CLR_CELL, 31, 31, 0, 0, 0));
      enqueue_item(make_item(3'd5, 0, 0, 0, 0, 0));
      enqueue_item(make_item(3'd7, 31, 31, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
      wait_idle();

      // Full grid with extreme axis values, extreme cells and a clear of an unset cell.
      write_csr(CSR_ROWS, 6'd32);
      write_csr(CSR_POINTS, 6'd32);
      load_axes(32, 32, 1'b1);
      wait_idle();
      enqueue_item(make_item(ACT_CLR_CELL, 4, 4, 0, 0, 0));
      enqueue_item(make_item(ACT_QUERY, 0, 0, 24'd500, 16'sd0, 0));
      enqueue_item(make_item(ACT_WR_CELL, 0, 0, 0, 0, 16'h7FFF));
      enqueue_item(make_item(ACT_WR_CELL, 31, 31, 0, 0, 16'h8000));
      enqueue_item(make_item(ACT_WR_CELL, 31, 0, 0, 0, 16'h7FFF));
      enqueue_item(make_item(ACT_QUERY, 0, 0, 24'd0, 16'h8000, 0));
      enqueue_item(make_item(ACT_QUERY, 0, 0, 24'hFFFFFF, 16'h7FFF, 0));
      enqueue_item(make_item(ACT_QUERY, 0, 0, 24'hFFFFF0, 16'h7FF0, 0));
      enqueue_item(make_item(ACT_WR_CELL, 32'd32, 0, 0, 0, 0));
      enqueue_item(make_item(ACT_CLR_CELL, 31, 31, 0, 0, 0));
      enqueue_item(make_item(ACT_QUERY, 0, 0, 24'hFFFFFF, 16'h7FFF, 0));
      wait_idle();

      // Random phases; the sender holds off once until every result has come.
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_ROWS, phase_rows[ph]);
         write_csr(CSR_POINTS, phase_pts[ph]);
         nr = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
         np = (points_cfg > MAX_POWER_POINTS) ? MAX_POWER_POINTS : points_cfg;
         load_axes(nr, np, 1'b0);
         wait_idle();
         stall_free = (ph == 2);
         for (int k = 0; k < 145; k++) begin
            enqueue_item(random_item(nr, np));
            if (ph == 1 && k == 90) begin
               while (pending_items.size() > 0 || req_valid) @(posedge clock);
               hold_sender = 1'b1;
               while (expected_rsps.size() > 0) @(posedge clock);
               hold_sender = 1'b0;
            end
            if (pending_items.size() > 4) @(posedge clock);
            while (pending_items.size() > 4) @(posedge clock);
         end
         wait_idle();
         stall_free = 1'b0;
      end

      wait_idle();
      repeat (300) @(posedge clock);
      $display("covered %0d results, %0d of them queries, over 8 settings of the counts in use",
               rsp_count, query_count);
      $display("empty grid, out-of-use indexes, unknown actions and axis extremes included");
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("bilinear_calibration_grid_lookup_tb: done, clean");
      end else begin
         $display("%0d mismatches, %0d expectations left", error_count, expected_rsps.size());
         $display("bilinear_calibration_grid_lookup_tb: done, errors");
      end
      $finish;
   end

endmodule

[bilinear_calibration_grid_lookup.f]
rtl/core/bcgl_pkg.sv
rtl/core/bcgl_ram.sv
rtl/core/bcgl_div.sv
rtl/core/bilinear_calibration_grid_lookup.sv
verif/bilinear_calibration_grid_lookup_tb.sv
